[hw/rtl/pfe_pkg.sv]
package pfe_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned FMT_W    = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 8;
   localparam int unsigned PACK_W   = 32;
   localparam int unsigned COUNT_W  = 3;
   localparam int unsigned QMUL_W   = 6;

   typedef enum logic [FMT_W-1:0] {
      PIX_RGB888   = 3'd0,
      PIX_RGB565   = 3'd1,
      PIX_RGB332   = 3'd2,
      PIX_ARGB8888 = 3'd3,
      PIX_ARGB8565 = 3'd4,
      PIX_ARGB4444 = 3'd5,
      PIX_ARGB2222 = 3'd6
   } fmt_type;

   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_ENABLE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_RED     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_GREEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_BLUE    = 3'd4;

   // floor(x/255), exact for x below 65280
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

endpackage

[hw/rtl/pfe_if.sv]
interface pfe_req_if import pfe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [CHAN_W-1:0] alpha;
   logic              last_pixel;

   modport source (output valid, red, green, blue, alpha, last_pixel, input ready);
   modport sink   (input valid, red, green, blue, alpha, last_pixel, output ready);
endinterface

interface pfe_rsp_if import pfe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PACK_W-1:0]  packed_bytes;
   logic [COUNT_W-1:0] byte_count;
   logic               last_out;

   modport source (output valid, packed_bytes, byte_count, last_out, input ready);
   modport sink   (input valid, packed_bytes, byte_count, last_out, output ready);
endinterface

interface pfe_csr_if import pfe_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[hw/rtl/rgba_pixel_format_encoder.sv]
// Channel   Dir  Payload
// req_bus   in   red, green, blue, alpha, last_pixel
// rsp_bus   out  packed_bytes, byte_count, last_out
// csr_bus   in   index, wdata (always ready)
//
// Four register stages: alpha multiply, blend divide, quantize multiply, divide and pack.
// One pixel per clock sustained while rsp_bus.ready holds; an accepted beat passes through
// the s1, s2, s3 and s4 registers in order before rsp_bus.valid presents it.
// Each stage holds its beat while the one after it is full and stalled.
// Reset (synchronous) empties the pipe and clears all csr registers.
module rgba_pixel_format_encoder import pfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pfe_req_if.sink    req_bus,
   pfe_rsp_if.source  rsp_bus,
   pfe_csr_if.sink    csr_bus
);

   // ---------------- csr registers ----------------
   fmt_type           fmt_ff;
   logic              fill_en_ff;
   logic [CHAN_W-1:0] fill_ff [3];

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= PIX_RGB888;
         fill_en_ff <= 1'b0;
         fill_ff[0] <= '0;
         fill_ff[1] <= '0;
         fill_ff[2] <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_PIXEL_FORMAT: fmt_ff     <= fmt_type'(csr_bus.wdata[FMT_W-1:0]);
            CSR_FILL_ENABLE:  fill_en_ff <= csr_bus.wdata[0];
            CSR_FILL_RED:     fill_ff[0] <= csr_bus.wdata;
            CSR_FILL_GREEN:   fill_ff[1] <= csr_bus.wdata;
            CSR_FILL_BLUE:    fill_ff[2] <= csr_bus.wdata;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic s1_vld_in, s2_vld_in, s3_vld_in, s4_vld_in;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !s4_vld_ff || rsp_bus.ready;
   assign rdy3 = !s3_vld_ff || rdy4;
   assign rdy2 = !s2_vld_ff || rdy3;
   assign rdy1 = !s1_vld_ff || rdy2;
   assign req_bus.ready = rdy1;

   assign s1_vld_in = rdy1 ? req_bus.valid : s1_vld_ff;
   assign s2_vld_in = rdy2 ? s1_vld_ff     : s2_vld_ff;
   assign s3_vld_in = rdy3 ? s2_vld_ff     : s3_vld_ff;
   assign s4_vld_in = rdy4 ? s3_vld_ff     : s4_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         s4_vld_ff <= s4_vld_in;
      end
   end

   // ---------------- stage 1: blend products ----------------
   // Without blending, weight 255 on the pixel and 0 on the fill gives c back.
   logic              blend;
   logic [CHAN_W-1:0] a_eff;
   logic [CHAN_W-1:0] pix [3];
   logic [15:0]       s1_ca_in [3];
   logic [15:0]       s1_fa_in [3];
   logic [15:0]       s1_ca_ff [3];
   logic [15:0]       s1_fa_ff [3];
   logic [CHAN_W-1:0] s1_a_ff;
   logic              s1_last_ff;
   fmt_type           s1_fmt_ff;

   assign pix[0] = req_bus.red;
   assign pix[1] = req_bus.green;
   assign pix[2] = req_bus.blue;

   always_comb begin
      blend = fill_en_ff && (req_bus.alpha != 8'hFF)
              && !(fmt_ff == PIX_ARGB8888 || fmt_ff == PIX_ARGB8565
                   || fmt_ff == PIX_ARGB4444 || fmt_ff == PIX_ARGB2222);
      a_eff = blend ? req_bus.alpha : 8'hFF;
      for (int i = 0; i < 3; i++) begin
         s1_ca_in[i] = 16'(pix[i]) * 16'(a_eff);
         s1_fa_in[i] = 16'(fill_ff[i]) * 16'(8'hFF - a_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_bus.valid) begin
         for (int i = 0; i < 3; i++) begin
            s1_ca_ff[i] <= s1_ca_in[i];
            s1_fa_ff[i] <= s1_fa_in[i];
         end
         s1_a_ff    <= req_bus.alpha;
         s1_last_ff <= req_bus.last_pixel;
         s1_fmt_ff  <= fmt_ff;
      end
   end

   // ---------------- stage 2: round((c*a+f*(255-a))/255) ----------------
   logic [CHAN_W-1:0] s2_c_in [3];
   logic [CHAN_W-1:0] s2_c_ff [3];
   logic [CHAN_W-1:0] s2_a_ff;
   logic              s2_last_ff;
   fmt_type           s2_fmt_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // sum stays at or below 255*255, so +127 still fits 16 bits
         s2_c_in[i] = div255(s1_ca_ff[i] + s1_fa_ff[i] + 16'd127);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && s1_vld_ff) begin
         s2_c_ff    <= s2_c_in;
         s2_a_ff    <= s1_a_ff;
         s2_last_ff <= s1_last_ff;
         s2_fmt_ff  <= s1_fmt_ff;
      end
   end

   // ---------------- stage 3: quantize products c*(2^n-1) ----------------
   // lane 0 red, 1 green, 2 blue, 3 alpha
   logic [CHAN_W-1:0] s2_ch [4];
   logic [QMUL_W-1:0] qmax [4];
   logic [13:0]       s3_qp_in [4];
   logic [13:0]       s3_qp_ff [4];
   logic [CHAN_W-1:0] s3_ch_ff [4];
   logic              s3_last_ff;
   fmt_type           s3_fmt_ff;

   assign s2_ch[0] = s2_c_ff[0];
   assign s2_ch[1] = s2_c_ff[1];
   assign s2_ch[2] = s2_c_ff[2];
   assign s2_ch[3] = s2_a_ff;

   always_comb begin
      case (s2_fmt_ff)
         PIX_RGB565, PIX_ARGB8565: begin
            qmax[0] = 6'd31; qmax[1] = 6'd63; qmax[2] = 6'd31; qmax[3] = 6'd0;
         end
         PIX_RGB332: begin
            qmax[0] = 6'd7;  qmax[1] = 6'd7;  qmax[2] = 6'd3;  qmax[3] = 6'd0;
         end
         PIX_ARGB4444: begin
            qmax[0] = 6'd15; qmax[1] = 6'd15; qmax[2] = 6'd15; qmax[3] = 6'd15;
         end
         PIX_ARGB2222: begin
            qmax[0] = 6'd3;  qmax[1] = 6'd3;  qmax[2] = 6'd3;  qmax[3] = 6'd3;
         end
         default: begin
            qmax[0] = 6'd0;  qmax[1] = 6'd0;  qmax[2] = 6'd0;  qmax[3] = 6'd0;
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         s3_qp_in[i] = 14'(s2_ch[i]) * 14'(qmax[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && s2_vld_ff) begin
         s3_qp_ff   <= s3_qp_in;
         s3_ch_ff   <= s2_ch;
         s3_last_ff <= s2_last_ff;
         s3_fmt_ff  <= s2_fmt_ff;
      end
   end

   // ---------------- stage 4: divide and pack ----------------
   logic [CHAN_W-1:0]  q [4];
   logic [15:0]        w565;
   logic [PACK_W-1:0]  s4_pack_in, s4_pack_ff;
   logic [COUNT_W-1:0] s4_cnt_in, s4_cnt_ff;
   logic               s4_last_ff;
   fmt_type            s4_fmt_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q[i] = div255(16'(s3_qp_ff[i]) + 16'd127);
      end
      w565 = {q[0][4:0], q[1][5:0], q[2][4:0]};
      case (s3_fmt_ff)
         PIX_RGB565: begin
            s4_pack_in = {16'h0, w565};
            s4_cnt_in  = 3'd2;
         end
         PIX_RGB332: begin
            s4_pack_in = {24'h0, q[0][2:0], q[1][2:0], q[2][1:0]};
            s4_cnt_in  = 3'd1;
         end
         PIX_ARGB8888: begin
            s4_pack_in = {s3_ch_ff[3], s3_ch_ff[0], s3_ch_ff[1], s3_ch_ff[2]};
            s4_cnt_in  = 3'd4;
         end
         PIX_ARGB8565: begin
            s4_pack_in = {8'h0, s3_ch_ff[3], w565};
            s4_cnt_in  = 3'd3;
         end
         PIX_ARGB4444: begin
            s4_pack_in = {16'h0, q[3][3:0], q[0][3:0], q[1][3:0], q[2][3:0]};
            s4_cnt_in  = 3'd2;
         end
         PIX_ARGB2222: begin
            s4_pack_in = {24'h0, q[3][1:0], q[0][1:0], q[1][1:0], q[2][1:0]};
            s4_cnt_in  = 3'd1;
         end
         default: begin
            // rgb888 and the unused code
            s4_pack_in = {8'h0, s3_ch_ff[0], s3_ch_ff[1], s3_ch_ff[2]};
            s4_cnt_in  = 3'd3;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy4 && s3_vld_ff) begin
         s4_pack_ff <= s4_pack_in;
         s4_cnt_ff  <= s4_cnt_in;
         s4_last_ff <= s3_last_ff;
         s4_fmt_ff  <= s3_fmt_ff;
      end
   end

   assign rsp_bus.valid        = s4_vld_ff;
   assign rsp_bus.packed_bytes = s4_pack_ff;
   assign rsp_bus.byte_count   = s4_cnt_ff;
   assign rsp_bus.last_out     = s4_last_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.byte_count != 3'd0 && rsp_bus.byte_count <= 3'd4))
      else $error("byte_count out of range");

   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.byte_count == 3'd1) |-> (rsp_bus.packed_bytes[31:8] == 24'h0))
      else $error("bytes above byte_count not zero");

   a_four_only_8888: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.byte_count == 3'd4) |-> (s4_fmt_ff == PIX_ARGB8888))
      else $error("four bytes for a format other than argb8888");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_bus.valid && !s1_vld_ff && !s2_vld_ff && !s3_vld_ff))
      else $error("pipe not empty after reset");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s2_vld_ff && s3_vld_ff && s4_vld_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input taken while pipe full and stalled");
`endif

endmodule

[dv/rgba_pixel_format_encoder_tb.sv]
module rgba_pixel_format_encoder_tb import pfe_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PIPE_DEPTH  = 4;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASES      = 12;
   localparam int unsigned PHASE_BEATS = 32;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [PACK_W-1:0]  packed_bytes;
      logic [COUNT_W-1:0] byte_count;
      logic               last_out;
   } word_type;

   class pixel_scoreboard;
      logic [FMT_W-1:0]  fmt = PIX_RGB888;
      logic              fill_en = 1'b0;
      logic [CHAN_W-1:0] fill_r = '0;
      logic [CHAN_W-1:0] fill_g = '0;
      logic [CHAN_W-1:0] fill_b = '0;
      word_type          pending_words[$];
      int unsigned       errors = 0;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_PIXEL_FORMAT: fmt = data[FMT_W-1:0];
            CSR_FILL_ENABLE:  fill_en = data[0];
            CSR_FILL_RED:     fill_r = data;
            CSR_FILL_GREEN:   fill_g = data;
            CSR_FILL_BLUE:    fill_b = data;
            default: ;
         endcase
      endfunction

      // round(c*top/255), halves up
      static function int unsigned requant(int unsigned c, int unsigned top);
         return (2 * c * top + 255) / 510;
      endfunction

      // round((c*a + f*(255-a))/255), halves up
      static function int unsigned mix(int unsigned c, int unsigned f, int unsigned a);
         return (2 * (c * a + f * (255 - a)) + 255) / 510;
      endfunction

      function void note_pixel(pixel_type p);
         int unsigned r, g, b, a, w565;
         word_type w;
         r = p.red;
         g = p.green;
         b = p.blue;
         a = p.alpha;
         if (a < 255 && fill_en && !(fmt >= PIX_ARGB8888 && fmt <= PIX_ARGB2222)) begin
            r = mix(r, fill_r, a);
            g = mix(g, fill_g, a);
            b = mix(b, fill_b, a);
         end
         w565 = (requant(r, 31) << 11) | (requant(g, 63) << 5) | requant(b, 31);
         w.last_out = p.last_pixel;
         case (fmt)
            PIX_RGB565: begin
               w.packed_bytes = w565;
               w.byte_count = 3'd2;
            end
            PIX_RGB332: begin
               w.packed_bytes = (requant(r, 7) << 5) | (requant(g, 7) << 2) | requant(b, 3);
               w.byte_count = 3'd1;
            end
            PIX_ARGB8888: begin
               w.packed_bytes = b | (g << 8) | (r << 16) | (a << 24);
               w.byte_count = 3'd4;
            end
            PIX_ARGB8565: begin
               w.packed_bytes = w565 | (a << 16);
               w.byte_count = 3'd3;
            end
            PIX_ARGB4444: begin
               w.packed_bytes = (requant(a, 15) << 12) | (requant(r, 15) << 8)
                              | (requant(g, 15) << 4) | requant(b, 15);
               w.byte_count = 3'd2;
            end
            PIX_ARGB2222: begin
               w.packed_bytes = (requant(a, 3) << 6) | (requant(r, 3) << 4)
                              | (requant(g, 3) << 2) | requant(b, 3);
               w.byte_count = 3'd1;
            end
            default: begin // rgb888 and the spare code
               w.packed_bytes = b | (g << 8) | (r << 16);
               w.byte_count = 3'd3;
            end
         endcase
         pending_words.push_back(w);
      endfunction

      function void check_result(word_type got);
         word_type want;
         if (pending_words.size() == 0) begin
            $display("%0t: packed_bytes expected none actual %h", $time,
                     got.packed_bytes);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         if (want.packed_bytes !== got.packed_bytes) begin
            $display("%0t: packed_bytes expected %h actual %h", $time,
                     want.packed_bytes, got.packed_bytes);
            errors++;
         end
         if (want.byte_count !== got.byte_count) begin
            $display("%0t: byte_count expected %0d actual %0d", $time,
                     want.byte_count, got.byte_count);
            errors++;
         end
         if (want.last_out !== got.last_out) begin
            $display("%0t: last_out expected %b actual %b", $time,
                     want.last_out, got.last_out);
            errors++;
         end
      endfunction

      function int pending();
         return pending_words.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int unsigned idle_pct = 0;
   bit hold_request = 1'b0;
   int unsigned cycle_count = 0;
   pixel_scoreboard sb;

   pfe_req_if req_bus();
   pfe_rsp_if rsp_bus();
   pfe_csr_if csr_bus();

   rgba_pixel_format_encoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rgba_pixel_format_encoder verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result({rsp_bus.packed_bytes, rsp_bus.byte_count, rsp_bus.last_out});
   end

   // result side: random stall bursts, plus one long hold-off to back up the pipe
   initial begin : rsp_sink
      bit hold_done;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if ($urandom_range(0, 99) < idle_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(0, 10)) @(posedge clock);
         end
      end
   end

   function automatic logic [CHAN_W-1:0] pick_channel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p.red = pick_channel();
      p.green = pick_channel();
      p.blue = pick_channel();
      case ($urandom_range(0, 7))
         0, 1: p.alpha = 8'd255;
         2: p.alpha = 8'd0;
         default: p.alpha = 8'($urandom_range(0, 255));
      endcase
      p.last_pixel = ($urandom_range(0, 7) == 0);
      return p;
   endfunction

   // writes every register back to back, then one beat to an unmapped index
   task automatic program_regs(input logic [CSR_DAT_W-1:0] fmt_word,
                               input logic [CSR_DAT_W-1:0] en_word,
                               input logic [CSR_DAT_W-1:0] r,
                               input logic [CSR_DAT_W-1:0] g,
                               input logic [CSR_DAT_W-1:0] b);
      logic [CSR_IDX_W-1:0] idx [6];
      logic [CSR_DAT_W-1:0] val [6];
      idx = '{CSR_PIXEL_FORMAT, CSR_FILL_ENABLE, CSR_FILL_RED, CSR_FILL_GREEN,
              CSR_FILL_BLUE, CSR_FILL_BLUE + CSR_IDX_W'($urandom_range(1, 3))};
      val = '{fmt_word, en_word, r, g, b, CSR_DAT_W'($urandom_range(0, 255))};
      for (int i = 0; i < 6; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx[i];
         csr_bus.wdata <= val[i];
         @(posedge clock);
         while (!csr_bus.ready) @(posedge clock);
         sb.write_reg(idx[i], val[i]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_pixel(input pixel_type p);
      req_bus.valid      <= 1'b1;
      req_bus.red        <= p.red;
      req_bus.green      <= p.green;
      req_bus.blue       <= p.blue;
      req_bus.alpha      <= p.alpha;
      req_bus.last_pixel <= p.last_pixel;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_pixel(p);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic stop_pixels();
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   initial begin : stimulus
      pixel_type p;
      logic [FMT_W-1:0] fmt;
      logic [CSR_DAT_W-1:0] fr, fg, fb;
      logic [4:0] junk_hi;
      logic [6:0] junk_en;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.red = '0;
      req_bus.green = '0;
      req_bus.blue = '0;
      req_bus.alpha = '0;
      req_bus.last_pixel = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.wdata = '0;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // every format code, fill on: transparent black, opaque white, half alpha
      idle_pct = 25;
      for (int f = 0; f < 8; f++) begin
         program_regs(CSR_DAT_W'(f), 8'd1, 8'd255, 8'd0, 8'd128);
         send_pixel('{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0, last_pixel: 1'b0});
         send_pixel('{red: 8'd255, green: 8'd255, blue: 8'd255, alpha: 8'd255,
                      last_pixel: 1'b0});
         p = random_pixel();
         p.alpha = 8'd128;
         p.last_pixel = 1'b1;
         send_pixel(p);
         stop_pixels();
         wait_drain();
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         fmt = (ph < 8) ? FMT_W'(ph) : FMT_W'($urandom_range(0, 7));
         case ($urandom_range(0, 3))
            0: begin fr = 8'd0;   fg = 8'd0;   fb = 8'd0;   end
            1: begin fr = 8'd255; fg = 8'd255; fb = 8'd255; end
            default: begin
               fr = 8'($urandom_range(0, 255));
               fg = 8'($urandom_range(0, 255));
               fb = 8'($urandom_range(0, 255));
            end
         endcase
         // upper data bits beyond the field width must be dropped
         junk_hi = (ph % 2) ? 5'($urandom_range(0, 31)) : 5'd0;
         junk_en = (ph % 2) ? 7'($urandom_range(0, 127)) : 7'd0;
         program_regs({junk_hi, fmt}, {junk_en, 1'($urandom_range(0, 1))}, fr, fg, fb);
         if (ph >= PHASES - 2 || ph % 3 == 1)
            idle_pct = 0;
         else
            idle_pct = 30;
         if (ph == 2)
            hold_request = 1'b1;
         for (int i = 0; i < PHASE_BEATS; i++)
            send_pixel(random_pixel());
         stop_pixels();
         wait_drain();
      end

      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("rgba_pixel_format_encoder verification clean");
      else
         $display("rgba_pixel_format_encoder verification failed");
      $finish;
   end

endmodule
